@@ rtl/masked_route_first_match_table_assert.svh @@
// Assertion macros used by the checker file of the route table.
`ifndef MASKED_ROUTE_FIRST_MATCH_TABLE_ASSERT_SVH
`define MASKED_ROUTE_FIRST_MATCH_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRFMT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("route table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MRFMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("route table assertion failed");

`endif

@@ rtl/mrfmt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mrfmt_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 16;
   localparam int ADDR_WIDTH = 32;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   typedef logic [ADDR_WIDTH-1:0] addr_type;

   typedef struct packed {
      addr_type network;
      addr_type mask;
      addr_type next_hop;
   } route_entry_type;

endpackage

`default_nettype wire

@@ rtl/mrfmt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mrfmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                                       clock,
   input  wire                                       wr_en,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire [WIDTH-1:0]                           wr_data,
   input  wire                                       rd_en,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/mrfmt_match.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mrfmt_match (
   input  wire mrfmt_pkg::addr_type        lookup_address,
   input  wire mrfmt_pkg::route_entry_type entry,
   output logic                            match
);

   import mrfmt_pkg::*;

   // A bit that the mask clears never takes part in the compare.
   assign match = ((lookup_address ^ entry.network) & entry.mask) == '0;

endmodule

`default_nettype wire

@@ rtl/masked_route_first_match_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake         Payload
// req_      in         req_valid/stall   operation, lookup_address, new_next_hop,
//                                        new_network, new_mask
// rsp_      out        rsp_valid/stall   hit, found_next_hop, table_full
//
// A lookup scans stored routes in order to the first match, one compare per cycle
// after the first table read, set by the single table read port and compare unit.
// Reset empties the table at once; no clearing pass is needed.
// A stalled response is held in the output register while the next transaction
// is accepted; a finished result waits in a holding register if the output is full.

module masked_route_first_match_table #(
   parameter int TABLE_ENTRIES = mrfmt_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire                  req_operation,
   input  wire mrfmt_pkg::addr_type req_lookup_address,
   input  wire mrfmt_pkg::addr_type req_new_next_hop,
   input  wire mrfmt_pkg::addr_type req_new_network,
   input  wire mrfmt_pkg::addr_type req_new_mask,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic                 rsp_hit,
   output mrfmt_pkg::addr_type  rsp_found_next_hop,
   output logic                 rsp_table_full
);

   import mrfmt_pkg::*;

   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]      state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   scan_idx_ff, scan_idx_in;
   logic            pend_ff, pend_in;
   addr_type        addr_ff, addr_in;
   logic            hold_hit_ff, hold_hit_in;
   addr_type        hold_hop_ff, hold_hop_in;
   logic            hold_full_ff, hold_full_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_hit_ff, rsp_hit_in;
   addr_type        rsp_hop_ff, rsp_hop_in;
   logic            rsp_full_ff, rsp_full_in;

   logic            req_accept;
   logic            out_free;
   logic            table_is_full;
   logic            scan_done;
   logic            is_match;
   logic            wr_en;
   logic            rd_en;
   logic            fin_valid;
   logic            fin_hit;
   addr_type        fin_hop;
   logic            fin_full;
   route_entry_type wr_entry;
   route_entry_type rd_entry;

   assign req_stall     = (state_ff != ST_IDLE);
   assign req_accept    = req_valid && !req_stall;
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign table_is_full = (count_ff == CW'(TABLE_ENTRIES));
   assign scan_done     = (scan_idx_ff == count_ff);

   assign wr_entry.network  = req_new_network;
   assign wr_entry.mask     = req_new_mask;
   assign wr_entry.next_hop = req_new_next_hop;

   mrfmt_ram #(
      .WIDTH($bits(route_entry_type)),
      .DEPTH(TABLE_ENTRIES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(wr_entry),
      .rd_en  (rd_en),
      .rd_addr(scan_idx_ff[AW-1:0]),
      .rd_data(rd_entry)
   );

   mrfmt_match u_match (
      .lookup_address(addr_ff),
      .entry         (rd_entry),
      .match         (is_match)
   );

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      scan_idx_in = scan_idx_ff;
      pend_in     = 1'b0;
      addr_in     = addr_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      fin_valid   = 1'b0;
      fin_hit     = 1'b0;
      fin_hop     = '0;
      fin_full    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               addr_in = req_lookup_address;
               if (req_operation == OP_INSERT) begin
                  fin_valid = 1'b1;
                  if (table_is_full) begin
                     fin_full = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
               end else if (count_ff == '0) begin
                  fin_valid = 1'b1;
               end else begin
                  state_in    = ST_SCAN;
                  scan_idx_in = '0;
               end
            end
         end
         ST_SCAN: begin
            rd_en   = !scan_done;
            pend_in = !scan_done;
            if (!scan_done) begin
               scan_idx_in = scan_idx_ff + CW'(1);
            end
            if (pend_ff && is_match) begin
               fin_valid = 1'b1;
               fin_hit   = 1'b1;
               fin_hop   = rd_entry.next_hop;
            end else if (pend_ff && scan_done) begin
               fin_valid = 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (fin_valid) begin
         state_in = out_free ? ST_IDLE : ST_DONE;
      end
   end

   always_comb begin
      hold_hit_in  = hold_hit_ff;
      hold_hop_in  = hold_hop_ff;
      hold_full_in = hold_full_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_hop_in   = rsp_hop_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (fin_valid && !out_free) begin
         hold_hit_in  = fin_hit;
         hold_hop_in  = fin_hop;
         hold_full_in = fin_full;
      end

      if (fin_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = fin_hit;
         rsp_hop_in   = fin_hop;
         rsp_full_in  = fin_full;
      end else if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hold_hit_ff;
         rsp_hop_in   = hold_hop_ff;
         rsp_full_in  = hold_full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      addr_ff      <= addr_in;
      hold_hit_ff  <= hold_hit_in;
      hold_hop_ff  <= hold_hop_in;
      hold_full_ff <= hold_full_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_hop_ff   <= rsp_hop_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_found_next_hop = rsp_hop_ff;
   assign rsp_table_full     = rsp_full_ff;

endmodule

`default_nettype wire

@@ rtl/mrfmt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "masked_route_first_match_table_assert.svh"

module mrfmt_checker (
   input wire                      clock,
   input wire                      reset,
   input wire                      rsp_valid,
   input wire                      rsp_stall,
   input wire                      rsp_hit,
   input wire mrfmt_pkg::addr_type rsp_found_next_hop,
   input wire                      rsp_table_full
);

   // A refused insert never reports a hit.
   `MRFMT_ASSERT_SAME(a_full_no_hit, clock, reset, rsp_valid && rsp_table_full, !rsp_hit)

   // A miss or an insert carries a zero next hop.
   `MRFMT_ASSERT_SAME(a_miss_zero_hop, clock, reset, rsp_valid && !rsp_hit,
      rsp_found_next_hop == '0)

   // A stalled transaction keeps its payload.
   `MRFMT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_hit) && $stable(rsp_found_next_hop) && $stable(rsp_table_full))

   // No transaction is offered in the first cycle after reset.
   `MRFMT_ASSERT_SAME(a_rsp_after_reset, clock, reset, $past(reset), !rsp_valid)

endmodule

bind masked_route_first_match_table mrfmt_checker u_mrfmt_checker (.*);

`default_nettype wire
